[src/clp_pkg.sv]
// shared types, codes and keyword table of the command line parser
package clp_pkg;

    localparam int CLP_QUEUE_DEPTH = 2;
    localparam int KW_COUNT = 5;
    localparam int KW_MAX_LEN = 8;
    localparam int MAX_DIGITS_W = 4;
    localparam logic [MAX_DIGITS_W-1:0] SHORT_DIGITS = 4'd5;
    localparam logic [MAX_DIGITS_W-1:0] LONG_DIGITS = 4'd10;
    localparam logic [34:0] SHORT_LIMIT = 35'd65535;
    localparam logic [34:0] LONG_LIMIT = 35'd2147483647;

    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_HASH = 8'd35;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;

    typedef enum logic [2:0] {
        CMD_EMPTY     = 3'd0,
        CMD_COMMENT   = 3'd1,
        CMD_ERROR     = 3'd2,
        CMD_ADD_USER  = 3'd3,
        CMD_DEL_USER  = 3'd4,
        CMD_ADD_MOVIE = 3'd5,
        CMD_DEL_MOVIE = 3'd6,
        CMD_MARATHON  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        K_NL    = 3'd0,
        K_SP    = 3'd1,
        K_HASH  = 3'd2,
        K_DIGIT = 3'd3,
        K_OTHER = 3'd4,
        K_EOI   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic [7:0] ch;
    } t_token;

    // keyword byte i sits in bits 8i+7..8i
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0072657355646461,
        64'h00726573556c6564,
        64'h6569766f4d646461,
        64'h6569766f4d6c6564,
        64'h6e6f68746172616d
    };
    localparam logic [MAX_DIGITS_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd7, 4'd8, 4'd8, 4'd8
    };
    localparam t_cmd KW_CMD [KW_COUNT] = '{
        CMD_ADD_USER, CMD_DEL_USER, CMD_ADD_MOVIE, CMD_DEL_MOVIE, CMD_MARATHON
    };

endpackage

[src/clp_ifs.sv]
// valid/ready channel interfaces for text bytes and decoded commands
interface clp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;
    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface clp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] parent_id;
    logic [15:0] user_id;
    logic [30:0] long_arg;
    modport source (output valid, output command, output parent_id, output user_id,
                    output long_arg, input ready);
    modport sink (input valid, input command, input parent_id, input user_id,
                  input long_arg, output ready);
endinterface

[src/command_line_parser_top.sv]
// top level of the command line parser
// a line end byte passes the token queue register and then the result register before its result turns valid
// throughput: one byte per cycle while neither the queue nor a blocked result register stalls the flow
// a byte-to-token queue of QUEUE_DEPTH entries lets front and back stall apart
// reset: synchronous, active low; clears queue, line state and result valid at once
module command_line_parser_top #(
    parameter int QUEUE_DEPTH = clp_pkg::CLP_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clp_in_if.sink    i_in,
    clp_out_if.source o_res
);
    import clp_pkg::*;

    logic   push, full, q_valid, pop;
    t_token push_token, q_token;

    clp_front u_front (
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_token (push_token)
    );

    clp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_token (q_token)
    );

    clp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_token (q_token),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

[src/clp_front.sv]
// front end: accepts text bytes and classifies them into tokens
module clp_front (
    clp_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output clp_pkg::t_token o_token
);
    import clp_pkg::*;

    assign i_in.ready = !i_full;
    assign o_push = i_in.valid && !i_full;

    always_comb begin
        o_token.ch = i_in.byte_in;
        o_token.digit = i_in.byte_in[3:0];
        if (i_in.end_of_input) begin
            o_token.kind = K_EOI;
        end else if (i_in.byte_in == CH_NL) begin
            o_token.kind = K_NL;
        end else if (i_in.byte_in == CH_SP) begin
            o_token.kind = K_SP;
        end else if (i_in.byte_in == CH_HASH) begin
            o_token.kind = K_HASH;
        end else if (i_in.byte_in >= CH_ZERO && i_in.byte_in <= CH_NINE) begin
            o_token.kind = K_DIGIT;
        end else begin
            o_token.kind = K_OTHER;
        end
    end

endmodule

[src/clp_queue.sv]
// short token queue between front end and back end
module clp_queue #(
    parameter int DEPTH = clp_pkg::CLP_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clp_pkg::t_token i_token,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output clp_pkg::t_token o_token
);
    import clp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not reduce count");

endmodule

[src/clp_back.sv]
// back end: line state machine, argument decode and result register
module clp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  clp_pkg::t_token i_token,
    output logic            o_pop,
    clp_out_if.source       o_res
);
    import clp_pkg::*;

    typedef enum logic [5:0] {
        PH_START   = 6'b000001,
        PH_COMMENT = 6'b000010,
        PH_KEY     = 6'b000100,
        PH_ARG1    = 6'b001000,
        PH_ARG2    = 6'b010000,
        PH_SKIP    = 6'b100000
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [MAX_DIGITS_W-1:0] r_count, n_count;
    logic [KW_COUNT-1:0]     r_kw_hit, n_kw_hit;
    logic [30:0]             r_acc, n_acc;
    logic                    r_lz, n_lz;
    t_cmd                    r_pend, n_pend;
    logic [15:0]             r_first, n_first;

    logic        r_out_valid;
    t_cmd        r_out_cmd;
    logic [15:0] r_out_parent, r_out_user;
    logic [30:0] r_out_long;

    logic        emit;
    t_cmd        e_cmd;
    logic [15:0] e_parent, e_user;
    logic [30:0] e_long;
    logic        do_clear, do_fail;
    logic        is_long, want_nl, over, kw_found;
    t_cmd        kw_cmd;
    logic [34:0] acc10, nv;
    logic [5:0]  bit_pos;

    assign o_pop = i_valid && (!r_out_valid || o_res.ready);

    assign is_long = (r_phase == PH_ARG2) && (r_pend != CMD_ADD_USER);
    assign want_nl = (r_phase == PH_ARG2) || (r_pend == CMD_DEL_USER);
    assign acc10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
    assign nv = acc10 + {31'd0, i_token.digit};
    assign over = is_long ? (nv > LONG_LIMIT) : (nv > SHORT_LIMIT);
    assign bit_pos = {r_count[2:0], 3'b000};

    always_comb begin
        kw_found = 1'b0;
        kw_cmd = CMD_ERROR;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (r_kw_hit[k] && r_count == KW_LEN[k]) begin
                kw_found = 1'b1;
                kw_cmd = KW_CMD[k];
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_kw_hit = r_kw_hit;
        n_acc = r_acc;
        n_lz = r_lz;
        n_pend = r_pend;
        n_first = r_first;
        emit = 1'b0;
        e_cmd = CMD_ERROR;
        e_parent = '0;
        e_user = '0;
        e_long = '0;
        do_clear = 1'b0;
        do_fail = 1'b0;

        if (i_token.kind == K_EOI) begin
            if (r_phase == PH_COMMENT) begin
                emit = 1'b1;
                e_cmd = CMD_COMMENT;
            end else if (r_phase != PH_START) begin
                emit = 1'b1;
                e_cmd = CMD_ERROR;
            end
            do_clear = 1'b1;
        end else begin
            case (r_phase)
                PH_START, PH_KEY: begin
                    if (r_phase == PH_START && i_token.kind == K_NL) begin
                        emit = 1'b1;
                        e_cmd = CMD_EMPTY;
                    end else if (r_phase == PH_START && i_token.kind == K_HASH) begin
                        n_phase = PH_COMMENT;
                    end else if (i_token.kind == K_SP) begin
                        if (!kw_found) begin
                            do_fail = 1'b1;
                        end else begin
                            n_pend = kw_cmd;
                            n_phase = PH_ARG1;
                            n_count = '0;
                            n_acc = '0;
                            n_lz = 1'b0;
                        end
                    end else if (i_token.kind == K_NL
                                 || r_count >= MAX_DIGITS_W'(KW_MAX_LEN)) begin
                        do_fail = 1'b1;
                    end else begin
                        for (int k = 0; k < KW_COUNT; k++) begin
                            n_kw_hit[k] = r_kw_hit[k] && (r_count < KW_LEN[k])
                                          && (KW_TEXT[k][bit_pos +: 8] == i_token.ch);
                        end
                        n_count = r_count + MAX_DIGITS_W'(1);
                        n_phase = PH_KEY;
                    end
                end
                PH_COMMENT: begin
                    if (i_token.kind == K_NL) begin
                        emit = 1'b1;
                        e_cmd = CMD_COMMENT;
                        do_clear = 1'b1;
                    end
                end
                PH_ARG1, PH_ARG2: begin
                    if (i_token.kind == K_DIGIT) begin
                        if (r_count >= (is_long ? LONG_DIGITS : SHORT_DIGITS)
                            || (r_count != '0 && r_lz) || over) begin
                            do_fail = 1'b1;
                        end else begin
                            n_acc = nv[30:0];
                            n_count = r_count + MAX_DIGITS_W'(1);
                        end
                        if (r_count == '0 && i_token.digit == 4'd0) begin
                            n_lz = 1'b1;
                        end
                    end else if (i_token.kind == K_SP || i_token.kind == K_NL) begin
                        if (r_count == '0 || ((i_token.kind == K_NL) != want_nl)) begin
                            do_fail = 1'b1;
                        end else if (i_token.kind == K_SP) begin
                            n_first = r_acc[15:0];
                            n_phase = PH_ARG2;
                            n_count = '0;
                            n_acc = '0;
                            n_lz = 1'b0;
                        end else begin
                            emit = 1'b1;
                            e_cmd = r_pend;
                            do_clear = 1'b1;
                            if (r_phase == PH_ARG1) begin
                                e_user = r_acc[15:0];
                            end else if (r_pend == CMD_ADD_USER) begin
                                e_parent = r_first;
                                e_user = r_acc[15:0];
                            end else begin
                                e_user = r_first;
                                e_long = r_acc;
                            end
                        end
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (i_token.kind == K_NL) begin
                        emit = 1'b1;
                        e_cmd = CMD_ERROR;
                        do_clear = 1'b1;
                    end
                end
                default: begin
                    do_clear = 1'b1;
                end
            endcase
        end

        if (do_fail) begin
            if (i_token.kind == K_NL) begin
                emit = 1'b1;
                e_cmd = CMD_ERROR;
                do_clear = 1'b1;
            end else begin
                n_phase = PH_SKIP;
            end
        end

        if (do_clear) begin
            n_phase = PH_START;
            n_count = '0;
            n_kw_hit = '1;
            n_acc = '0;
            n_lz = 1'b0;
            n_pend = CMD_EMPTY;
            n_first = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_count <= '0;
            r_kw_hit <= '1;
            r_acc <= '0;
            r_lz <= 1'b0;
            r_pend <= CMD_EMPTY;
            r_first <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_kw_hit <= n_kw_hit;
                r_acc <= n_acc;
                r_lz <= n_lz;
                r_pend <= n_pend;
                r_first <= n_first;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_cmd <= e_cmd;
            r_out_parent <= e_parent;
            r_out_user <= e_user;
            r_out_long <= e_long;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.command = r_out_cmd;
    assign o_res.parent_id = r_out_parent;
    assign o_res.user_id = r_out_user;
    assign o_res.long_arg = r_out_long;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LONG_DIGITS)
        else $error("character count out of range");
    a_plain_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd < CMD_ADD_USER)
        |-> (r_out_parent == '0 && r_out_user == '0 && r_out_long == '0))
        else $error("argument fields set on empty, comment or error");
    a_long_only_movie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd < CMD_ADD_MOVIE) |-> (r_out_long == '0))
        else $error("long argument set on a short-only command");
    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !o_pop)
        else $error("token taken while result is blocked");

endmodule

[tb/tb_command_line_parser_top.sv]
`timescale 1ns / 100ps
// self-checking testbench of the command line parser with directed and random text lines
module tb_command_line_parser_top;
    import clp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BYTES = 1320;
    localparam int DRAIN_CYCLES = 10;

    typedef enum {PH_START, PH_COMMENT, PH_KEY, PH_ARG1, PH_ARG2, PH_SKIP} t_parse_phase;

    typedef enum int {
        FLAW_NONE, FLAW_LEAD_ZERO, FLAW_OVERFLOW, FLAW_LONG_KEY, FLAW_CORRUPT,
        FLAW_DROP, FLAW_EXTRA_SPACE, FLAW_EXTRA_ARG, FLAW_CUT_EOI
    } t_line_flaw;

    typedef struct packed {
        t_cmd        command;
        logic [15:0] parent_id;
        logic [15:0] user_id;
        logic [30:0] long_arg;
    } t_cmd_result;

    class t_command_checker;
        t_parse_phase phase;
        logic [3:0]   count;
        logic [63:0]  key_buf;
        logic [31:0]  acc;
        bit           lead_zero;
        bit           line_err;
        t_cmd         pend_cmd;
        logic [15:0]  first_id;
        logic [15:0]  second_id;
        t_cmd_result  expected_cmds[$];
        int           failures;

        function new();
            failures = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase = PH_START;
            count = '0;
            key_buf = '0;
            acc = '0;
            lead_zero = 1'b0;
            line_err = 1'b0;
            pend_cmd = CMD_EMPTY;
            first_id = '0;
            second_id = '0;
        endfunction

        function void expect_cmd(t_cmd c, logic [15:0] p, logic [15:0] u, logic [30:0] l);
            t_cmd_result r;
            r.command = c;
            r.parent_id = p;
            r.user_id = u;
            r.long_arg = l;
            expected_cmds.push_back(r);
        endfunction

        function void reject(logic [7:0] ch);
            line_err = 1'b1;
            if (ch == CH_NL) begin
                clear_line();
                expect_cmd(CMD_ERROR, '0, '0, '0);
            end else begin
                phase = PH_SKIP;
            end
        endfunction

        function t_cmd match_keyword();
            for (int k = 0; k < KW_COUNT; k++) begin
                if (count == KW_LEN[k] && key_buf == KW_TEXT[k])
                    return KW_CMD[k];
            end
            return CMD_ERROR;
        endfunction

        function void keyword_char(logic [7:0] ch);
            t_cmd c;
            if (ch == CH_SP) begin
                c = match_keyword();
                if (c == CMD_ERROR) begin
                    reject(ch);
                end else begin
                    pend_cmd = c;
                    phase = PH_ARG1;
                    count = '0;
                    acc = '0;
                    lead_zero = 1'b0;
                end
            end else if (ch == CH_NL || count >= 4'd8) begin
                reject(ch);
            end else begin
                key_buf[8*count +: 8] = ch;
                count = count + 1'b1;
            end
        endfunction

        function void arg_char(logic [7:0] ch, bit second);
            bit          is_long;
            bit          want_nl;
            logic [3:0]  max_digits;
            logic [35:0] limit;
            logic [35:0] nv;
            t_cmd        c;
            logic [15:0] p;
            logic [15:0] u;
            logic [30:0] l;
            is_long = second && pend_cmd != CMD_ADD_USER;
            max_digits = is_long ? LONG_DIGITS : SHORT_DIGITS;
            limit = is_long ? {1'b0, LONG_LIMIT} : {1'b0, SHORT_LIMIT};
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                if (count >= max_digits || (count >= 1 && lead_zero)) begin
                    reject(ch);
                    return;
                end
                if (count == 0 && ch == CH_ZERO)
                    lead_zero = 1'b1;
                nv = {4'd0, acc} * 36'd10 + {28'd0, ch - CH_ZERO};
                if (nv > limit) begin
                    reject(ch);
                    return;
                end
                acc = nv[31:0];
                count = count + 1'b1;
            end else if (ch == CH_SP || ch == CH_NL) begin
                want_nl = second || pend_cmd == CMD_DEL_USER;
                if (count == 0 || ((ch == CH_NL) != want_nl)) begin
                    reject(ch);
                end else if (ch == CH_SP) begin
                    first_id = acc[15:0];
                    phase = PH_ARG2;
                    count = '0;
                    acc = '0;
                    lead_zero = 1'b0;
                end else begin
                    c = pend_cmd;
                    p = '0;
                    u = '0;
                    l = '0;
                    if (!second) begin
                        u = acc[15:0];
                    end else if (c == CMD_ADD_USER) begin
                        second_id = acc[15:0];
                        p = first_id;
                        u = second_id;
                    end else begin
                        u = first_id;
                        l = acc[30:0];
                    end
                    clear_line();
                    expect_cmd(c, p, u, l);
                end
            end else begin
                reject(ch);
            end
        endfunction

        function void note_byte(logic [7:0] ch, bit eoi);
            if (eoi) begin
                if (phase == PH_COMMENT)
                    expect_cmd(CMD_COMMENT, '0, '0, '0);
                else if (phase != PH_START)
                    expect_cmd(CMD_ERROR, '0, '0, '0);
                clear_line();
                return;
            end
            case (phase)
                PH_START: begin
                    if (ch == CH_NL) begin
                        expect_cmd(CMD_EMPTY, '0, '0, '0);
                    end else if (ch == CH_HASH) begin
                        phase = PH_COMMENT;
                    end else begin
                        clear_line();
                        phase = PH_KEY;
                        keyword_char(ch);
                    end
                end
                PH_COMMENT: begin
                    if (ch == CH_NL) begin
                        clear_line();
                        expect_cmd(CMD_COMMENT, '0, '0, '0);
                    end
                end
                PH_KEY: keyword_char(ch);
                PH_ARG1: arg_char(ch, 1'b0);
                PH_ARG2: arg_char(ch, 1'b1);
                default: begin
                    if (ch == CH_NL) begin
                        clear_line();
                        expect_cmd(CMD_ERROR, '0, '0, '0);
                    end
                end
            endcase
        endfunction

        function void report_field(string name, logic [30:0] want, logic [30:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_command(t_cmd_result got);
            t_cmd_result want;
            if (expected_cmds.size() == 0) begin
                failures++;
                $display("%0t: unexpected command %0d parent %0d user %0d long %0d",
                         $time, got.command, got.parent_id, got.user_id, got.long_arg);
                return;
            end
            want = expected_cmds.pop_front();
            report_field("command", want.command, got.command);
            report_field("parent_id", want.parent_id, got.parent_id);
            report_field("user_id", want.user_id, got.user_id);
            report_field("long_arg", want.long_arg, got.long_arg);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    clp_in_if         in_if ();
    clp_out_if        res_if ();
    t_command_checker cmd_board = new();
    logic [8:0]       text_q[$];
    int               bytes_sent;
    int               cycle_count;
    bit               calm_in;
    bit               calm_out;
    string            kw_names[KW_COUNT] = '{"addUser", "delUser", "addMovie", "delMovie",
                                             "marathon"};

    command_line_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back({1'b0, s[i]});
    endfunction

    function automatic void add_number(longint unsigned v);
        add_text($sformatf("%0d", v));
    endfunction

    function automatic void add_eoi();
        text_q.push_back(9'h100 | 9'($urandom_range(0, 255)));
    endfunction

    function automatic longint unsigned rand_arg(bit is_long);
        longint unsigned top;
        longint unsigned lo;
        longint unsigned hi;
        int              nd;
        int              r;
        top = is_long ? 64'd2147483647 : 64'd65535;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return top;
        nd = $urandom_range(1, is_long ? 10 : 5);
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (nd == 1)
            lo = 0;
        if (hi > top)
            hi = top;
        return lo + {$urandom, $urandom} % (hi - lo + 1);
    endfunction

    function automatic longint unsigned over_arg(bit is_long);
        if (is_long)
            return 64'd2147483648 + {$urandom, $urandom} % 64'd97852516352;
        return $urandom_range(65536, 999999);
    endfunction

    function automatic void build_command(t_line_flaw flaw);
        int              op;
        int              pos;
        int              bad_arg;
        bit              two;
        bit              long2;
        longint unsigned a1;
        longint unsigned a2;
        op = $urandom_range(0, KW_COUNT - 1);
        two = (op != 1);
        long2 = (op >= 2);
        bad_arg = two ? $urandom_range(1, 2) : 1;
        a1 = rand_arg(1'b0);
        a2 = rand_arg(long2);
        if (flaw == FLAW_OVERFLOW) begin
            if (bad_arg == 1)
                a1 = over_arg(1'b0);
            else
                a2 = over_arg(long2);
        end
        add_text(kw_names[op]);
        if (flaw == FLAW_LONG_KEY)
            text_q.push_back(9'($urandom_range(33, 126)));
        add_text(" ");
        if (flaw == FLAW_LEAD_ZERO && bad_arg == 1)
            add_text("0");
        add_number(a1);
        if (two) begin
            add_text(" ");
            if (flaw == FLAW_LEAD_ZERO && bad_arg == 2)
                add_text("0");
            add_number(a2);
        end
        if (flaw == FLAW_EXTRA_ARG) begin
            add_text(" ");
            add_number(rand_arg(1'b0));
        end
        add_text("\n");
        pos = $urandom_range(0, text_q.size() - 2);
        case (flaw)
            FLAW_CORRUPT: text_q[pos] = 9'($urandom_range(0, 255));
            FLAW_DROP: text_q.delete(pos);
            FLAW_EXTRA_SPACE: text_q.insert(pos, {1'b0, CH_SP});
            FLAW_CUT_EOI: begin
                while (text_q.size() > pos + 1)
                    void'(text_q.pop_back());
                add_eoi();
            end
            default: ;
        endcase
    endfunction

    function automatic void build_comment(bit eoi_end);
        int          n;
        logic [7:0]  ch;
        n = $urandom_range(0, 12);
        add_text("#");
        repeat (n) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == CH_NL)
                ch = ch + 1'b1;
            text_q.push_back({1'b0, ch});
        end
        if (eoi_end)
            add_eoi();
        else
            add_text("\n");
    endfunction

    function automatic void build_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) text_q.push_back(9'($urandom_range(0, 255)));
        add_text("\n");
    endfunction

    task automatic send_item(logic [8:0] item);
        int gap;
        gap = pick_gap(calm_in);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.byte_in <= item[7:0];
        in_if.end_of_input <= item[8];
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        cmd_board.note_byte(item[7:0], item[8]);
        bytes_sent++;
    endtask

    task automatic send_text();
        if ($urandom_range(0, 14) == 0)
            calm_in = !calm_in;
        foreach (text_q[i])
            send_item(text_q[i]);
        text_q.delete();
    endtask

    // result side: check every transfer, stall ready at random
    initial begin
        int          stall_left;
        t_cmd_result got;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.command = t_cmd'(res_if.command);
                got.parent_id = res_if.parent_id;
                got.user_id = res_if.user_id;
                got.long_arg = res_if.long_arg;
                cmd_board.check_command(got);
            end
            if ($urandom_range(0, 199) == 0)
                calm_out = !calm_out;
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                stall_left = pick_gap(calm_out);
            end
        end
    end

    initial begin
        int start;
        int r;
        in_if.valid <= 1'b0;
        in_if.byte_in <= 8'd0;
        in_if.end_of_input <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_text("\n");
        add_text("#");
        text_q.push_back(9'h000);
        text_q.push_back(9'h0FF);
        add_text("\n");
        add_text("addUser 0 65535\n");
        add_text("delUser 65535\n");
        add_text("addMovie 1 2147483647\n");
        add_text("delMovie 7 0\n");
        add_text("marathon 99 2147483648\n");
        add_text("addUser 65536 1\n");
        add_text("delUser 012\n");
        add_text("addMovie 5 12345678901\n");
        add_text("marathonX 1 2\n");
        add_text("delete 3\n");
        add_text("delUser\n");
        add_text("addUser 5\n");
        add_text("delUser 5 6\n");
        add_text("addMovie  5 6\n");
        add_eoi();
        add_text("addMovie 5");
        add_eoi();
        add_text("#note");
        add_eoi();
        send_text();

        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                build_command(FLAW_NONE);
            else if (r < 80)
                build_command(t_line_flaw'($urandom_range(1, 8)));
            else if (r < 87)
                build_comment($urandom_range(0, 3) == 0);
            else if (r < 91)
                add_text("\n");
            else if (r < 96)
                build_noise();
            else
                add_eoi();
            send_text();
        end
        in_if.valid <= 1'b0;

        while (cmd_board.expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (cmd_board.expected_cmds.size() != 0)
            $display("%0t: %0d commands never arrived", $time,
                     cmd_board.expected_cmds.size());
        if (cmd_board.failures == 0 && cmd_board.expected_cmds.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
